// ----- rtl/sbh_pkg.sv -----
// Package for the sample statistics histogram block.
// Holds the shared widths, limits, the job struct passed from front to back and the result struct.
// No dependencies.
package sbh_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SUM_W       = 42;
    localparam int MAX_BINS    = 62;
    localparam int BIN_W       = 6;
    localparam int BIN_DEPTH   = MAX_BINS + 1;
    localparam int TALLY_W     = 11;
    localparam int ACC_W       = 74;
    localparam int DIV_W       = 74;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int PROD_W      = SAMPLE_W + BIN_W;

    localparam logic [BIN_W-1:0]   BIN_COUNT_RESET = BIN_W'(8);
    localparam logic [TALLY_W-1:0] TALLY_MAX       = '1;

    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    // One finished set, handed from the front to the back
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
        logic                drop;
        logic [BIN_W-1:0]    n;
    } t_job;

    // One result item
    typedef struct packed {
        logic                kind;
        logic [SUM_W-1:0]    total;
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] maximum;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] std_dev;
        logic [BIN_W-1:0]    bin_index;
        logic [TALLY_W-1:0]  bin_tally;
        logic                overflowed;
        logic                final_res;
    } t_res;

endpackage

// ----- rtl/sbh_if.sv -----
// Channel interfaces of the sample statistics histogram block.
// Depends on sbh_pkg for field widths.
interface sbh_in_if;
    logic                         valid;
    logic                         ready;
    logic [sbh_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

interface sbh_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [sbh_pkg::SUM_W-1:0]    total;
    logic [sbh_pkg::SAMPLE_W-1:0] mean;
    logic [sbh_pkg::SAMPLE_W-1:0] maximum;
    logic [sbh_pkg::SAMPLE_W-1:0] minimum;
    logic [sbh_pkg::SAMPLE_W-1:0] std_dev;
    logic [sbh_pkg::BIN_W-1:0]    bin_index;
    logic [sbh_pkg::TALLY_W-1:0]  bin_tally;
    logic                         overflowed;
    logic                         final_res;
    modport source (output valid, kind, total, mean, maximum, minimum, std_dev,
                    bin_index, bin_tally, overflowed, final_res, input ready);
    modport sink   (input valid, kind, total, mean, maximum, minimum, std_dev,
                    bin_index, bin_tally, overflowed, final_res, output ready);
endinterface

interface sbh_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [sbh_pkg::BIN_W-1:0] bin_count;
    modport source (output valid, bin_count, input ready);
    modport sink   (input valid, bin_count, output ready);
endinterface

// ----- rtl/sbh_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sbh_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on sbh_pkg for DIV_W and SAMPLE_W.
module sbh_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sbh_pkg::DIV_W-1:0]    i_dividend,
    input  logic [sbh_pkg::SAMPLE_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [sbh_pkg::DIV_W-1:0]    o_quot
);
    localparam int STEP_W = $clog2(sbh_pkg::DIV_W + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [STEP_W-1:0]            r_step;
    logic [sbh_pkg::DIV_W-1:0]    r_q;
    logic [sbh_pkg::SAMPLE_W-1:0] r_d;
    logic [sbh_pkg::SAMPLE_W-1:0] r_rem;
    logic [sbh_pkg::SAMPLE_W:0]   n_trial;
    logic                         n_fit;

    // Shift in the next dividend bit and test against the divisor
    always_comb begin
        n_trial = {r_rem, r_q[sbh_pkg::DIV_W-1]};
        n_fit   = n_trial >= {1'b0, r_d};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(sbh_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? sbh_pkg::SAMPLE_W'(n_trial - {1'b0, r_d})
                           : n_trial[sbh_pkg::SAMPLE_W-1:0];
            r_q   <= {r_q[sbh_pkg::DIV_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- rtl/sbh_sqrt.sv -----
// Integer square root, one result bit per cycle, bit-pair method.
// Depends on sbh_pkg for SQ_W and SAMPLE_W.
module sbh_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sbh_pkg::SQ_W-1:0]     i_value,
    output logic                         o_done,
    output logic [sbh_pkg::SAMPLE_W-1:0] o_root
);
    localparam int RW     = sbh_pkg::SAMPLE_W + 3;
    localparam int STEP_W = $clog2(sbh_pkg::SAMPLE_W + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [STEP_W-1:0]            r_step;
    logic [sbh_pkg::SQ_W-1:0]     r_v;
    logic [RW-1:0]                r_rem;
    logic [sbh_pkg::SAMPLE_W-1:0] r_root;
    logic [RW-1:0]                n_rem;
    logic [RW-1:0]                n_trial;
    logic                         n_fit;

    // Bring down two bits and try root*4+1
    always_comb begin
        n_rem   = {r_rem[RW-3:0], r_v[sbh_pkg::SQ_W-1 -: 2]};
        n_trial = RW'({r_root, 2'b01});
        n_fit   = n_rem >= n_trial;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(sbh_pkg::SAMPLE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[sbh_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= n_fit ? n_rem - n_trial : n_rem;
            r_root <= {r_root[sbh_pkg::SAMPLE_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/sbh_front.sv -----
// Front of the statistics block: accepts samples, stores them, keeps running
// sum, min, max and count, and queues a finished set for the back end.
// Depends on sbh_pkg and sbh_in_if.
module sbh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sbh_in_if.sink                       i_in,
    input  logic [sbh_pkg::BIN_W-1:0]    i_bin_count,
    input  logic                         i_done,
    output logic                         o_job_valid,
    output sbh_pkg::t_job                o_job,
    input  logic                         i_job_ready,
    output logic                         o_ram_we,
    output logic [sbh_pkg::ADDR_W-1:0]   o_ram_waddr,
    output logic [sbh_pkg::SAMPLE_W-1:0] o_ram_wdata
);
    logic [sbh_pkg::CNT_W-1:0]    r_count;
    logic [sbh_pkg::SUM_W-1:0]    r_sum;
    logic [sbh_pkg::SAMPLE_W-1:0] r_min;
    logic [sbh_pkg::SAMPLE_W-1:0] r_max;
    logic                         r_drop;
    logic                         r_busy;
    sbh_pkg::t_job                r_q [2];
    logic                         r_wp;
    logic                         r_rp;
    logic [1:0]                   r_qcnt;

    logic                         n_accept;
    logic                         n_room;
    logic                         n_push;
    logic                         n_pop;
    sbh_pkg::t_job                n_job;
    logic [sbh_pkg::SAMPLE_W-1:0] n_x;

    assign i_in.ready = !r_busy && (r_qcnt != 2'd2);

    // Classify the beat and build the set summary it would close
    always_comb begin
        n_accept = i_in.valid && i_in.ready;
        n_room   = r_count < sbh_pkg::CNT_W'(sbh_pkg::MAX_SAMPLES);
        n_x      = i_in.sample;
        n_push   = n_accept && i_in.last;
        n_pop    = o_job_valid && i_job_ready;
        n_job.count = n_room ? r_count + 1'b1 : r_count;
        n_job.sum   = n_room ? r_sum + sbh_pkg::SUM_W'(n_x) : r_sum;
        n_job.min   = (n_room && n_x < r_min) ? n_x : r_min;
        n_job.max   = (n_room && n_x > r_max) ? n_x : r_max;
        n_job.drop  = r_drop || !n_room;
        if (i_bin_count == '0) begin
            n_job.n = sbh_pkg::BIN_W'(1);
        end else if (i_bin_count > sbh_pkg::BIN_W'(sbh_pkg::MAX_BINS)) begin
            n_job.n = sbh_pkg::BIN_W'(sbh_pkg::MAX_BINS);
        end else begin
            n_job.n = i_bin_count;
        end
    end

    // Store write
    assign o_ram_we    = n_accept && n_room;
    assign o_ram_waddr = r_count[sbh_pkg::ADDR_W-1:0];
    assign o_ram_wdata = n_x;

    // Running statistics; clear after a set closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_drop  <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            if (n_push) begin
                r_count <= '0;
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_drop  <= 1'b0;
                r_busy  <= 1'b1;
            end else if (n_accept) begin
                r_count <= n_job.count;
                r_sum   <= n_job.sum;
                r_min   <= n_job.min;
                r_max   <= n_job.max;
                r_drop  <= n_job.drop;
            end
            // Hold off new samples until the back end has finished the report
            if (i_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Job queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= '0;
        end else begin
            if (n_push) begin
                r_wp <= !r_wp;
            end
            if (n_pop) begin
                r_rp <= !r_rp;
            end
            r_qcnt <= r_qcnt + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

    // Job queue storage
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= n_job;
        end
    end

    assign o_job_valid = r_qcnt != '0;
    assign o_job       = r_q[r_rp];
endmodule

// ----- rtl/sbh_back.sv -----
// Back end of the statistics block: mean, variance pass, square root,
// histogram pass and report output.
// Depends on sbh_pkg, sbh_out_if, sbh_ram, sbh_div and sbh_sqrt.
module sbh_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  sbh_pkg::t_job                i_job,
    output logic                         o_job_ready,
    output logic [sbh_pkg::ADDR_W-1:0]   o_ram_raddr,
    input  logic [sbh_pkg::SAMPLE_W-1:0] i_ram_rdata,
    output logic                         o_done,
    sbh_out_if.source                    o_res
);
    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_MEAN      = 15'b000000000000010,
        S_VAR       = 15'b000000000000100,
        S_VDIV      = 15'b000000000001000,
        S_SQRT      = 15'b000000000010000,
        S_CLR       = 15'b000000000100000,
        S_BRD       = 15'b000000001000000,
        S_BWAIT     = 15'b000000010000000,
        S_BMUL      = 15'b000000100000000,
        S_BDIV      = 15'b000001000000000,
        S_BINC_WAIT = 15'b000010000000000,
        S_BINC_WR   = 15'b000100000000000,
        S_STAT      = 15'b001000000000000,
        S_HWAIT     = 15'b010000000000000,
        S_HOUT      = 15'b100000000000000
    } t_state;

    t_state                       r_state;
    sbh_pkg::t_job                r_job;
    logic [sbh_pkg::CNT_W-1:0]    r_idx;
    logic [sbh_pkg::BIN_W-1:0]    r_k;
    logic [sbh_pkg::SAMPLE_W-1:0] r_mean;
    logic [sbh_pkg::SAMPLE_W-1:0] r_std;
    logic [2:0]                   r_pv;
    logic [sbh_pkg::SAMPLE_W-1:0] r_d;
    logic [sbh_pkg::SQ_W-1:0]     r_sq;
    logic [sbh_pkg::ACC_W-1:0]    r_acc;
    logic [sbh_pkg::PROD_W-1:0]   r_prod;
    logic                         r_div_start;
    logic [sbh_pkg::DIV_W-1:0]    r_div_a;
    logic [sbh_pkg::SAMPLE_W-1:0] r_div_b;
    logic                         r_sqrt_start;
    logic [sbh_pkg::SQ_W-1:0]     r_sqrt_v;
    logic                         r_done;
    logic                         r_out_valid;
    sbh_pkg::t_res                r_res;

    logic                         div_done;
    logic [sbh_pkg::DIV_W-1:0]    div_quot;
    logic                         sqrt_done;
    logic [sbh_pkg::SAMPLE_W-1:0] sqrt_root;
    logic [sbh_pkg::TALLY_W-1:0]  bin_rdata;
    logic                         bin_we;
    logic [sbh_pkg::TALLY_W-1:0]  bin_wdata;
    logic [sbh_pkg::SAMPLE_W-1:0] n_span;
    logic [sbh_pkg::SAMPLE_W-1:0] n_diff;
    logic                         n_issue;
    logic                         n_out_free;

    // Shared divider for the mean, the variance and the bin number
    sbh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    sbh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_value (r_sqrt_v),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Bin counters
    sbh_ram #(
        .WIDTH (sbh_pkg::TALLY_W),
        .DEPTH (sbh_pkg::BIN_DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (r_k),
        .i_wdata (bin_wdata),
        .i_raddr (r_k),
        .o_rdata (bin_rdata)
    );

    always_comb begin
        n_span     = r_job.max - r_job.min;
        n_diff     = i_ram_rdata - r_job.min;
        n_issue    = (r_state == S_VAR) && (r_idx != r_job.count);
        n_out_free = !r_out_valid || o_res.ready;
        bin_we     = (r_state == S_CLR) || (r_state == S_BINC_WR);
        if (r_state == S_CLR) begin
            bin_wdata = '0;
        end else if (bin_rdata == sbh_pkg::TALLY_MAX) begin
            bin_wdata = bin_rdata;
        end else begin
            bin_wdata = bin_rdata + 1'b1;
        end
    end

    assign o_job_ready = r_state == S_IDLE;
    assign o_ram_raddr = r_idx[sbh_pkg::ADDR_W-1:0];
    assign o_done      = r_done;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pv         <= '0;
        end else begin
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_done       <= 1'b0;
            r_pv         <= {r_pv[1:0], n_issue};
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (!n_issue && r_pv == '0) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (div_done) begin
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    if (r_k == r_job.n) begin
                        r_state <= S_BRD;
                    end
                end
                S_BRD: begin
                    r_state <= (r_idx == r_job.count) ? S_STAT : S_BWAIT;
                end
                S_BWAIT: begin
                    r_state <= (n_span == '0) ? S_BINC_WAIT : S_BMUL;
                end
                S_BMUL: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_BDIV;
                end
                S_BDIV: begin
                    if (div_done) begin
                        r_state <= S_BINC_WAIT;
                    end
                end
                S_BINC_WAIT: begin
                    r_state <= S_BINC_WR;
                end
                S_BINC_WR: begin
                    r_state <= S_BRD;
                end
                S_STAT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_HWAIT;
                    end
                end
                S_HWAIT: begin
                    r_state <= S_HOUT;
                end
                S_HOUT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_k == r_job.n) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_HWAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        // Variance pipeline: read, distance, square, accumulate
        if (r_pv[0]) begin
            r_d <= (i_ram_rdata > r_mean) ? i_ram_rdata - r_mean : r_mean - i_ram_rdata;
        end
        if (r_pv[1]) begin
            r_sq <= sbh_pkg::SQ_W'(r_d) * sbh_pkg::SQ_W'(r_d);
        end
        if (r_pv[2]) begin
            r_acc <= r_acc + sbh_pkg::ACC_W'(r_sq);
        end
        if (n_issue) begin
            r_idx <= r_idx + 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_div_a <= sbh_pkg::DIV_W'(i_job.sum);
                r_div_b <= sbh_pkg::SAMPLE_W'(i_job.count);
            end
            S_MEAN: begin
                r_mean <= div_quot[sbh_pkg::SAMPLE_W-1:0];
                r_idx  <= '0;
                r_acc  <= '0;
            end
            S_VAR: begin
                r_div_a <= sbh_pkg::DIV_W'(r_acc);
            end
            S_VDIV: begin
                r_sqrt_v <= div_quot[sbh_pkg::SQ_W-1:0];
                r_k      <= '0;
            end
            S_SQRT: begin
                r_std <= sqrt_root;
                r_idx <= '0;
            end
            S_CLR: begin
                if (r_k != r_job.n) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_BWAIT: begin
                r_k    <= '0;
                r_prod <= sbh_pkg::PROD_W'(n_diff) * sbh_pkg::PROD_W'(r_job.n);
            end
            S_BMUL: begin
                r_div_a <= sbh_pkg::DIV_W'(r_prod);
                r_div_b <= n_span;
            end
            S_BDIV: begin
                r_k <= div_quot[sbh_pkg::BIN_W-1:0];
            end
            S_BINC_WR: begin
                r_idx <= r_idx + 1'b1;
            end
            S_STAT: begin
                if (n_out_free) begin
                    r_res            <= '0;
                    r_res.kind       <= sbh_pkg::KIND_STATS;
                    r_res.total      <= r_job.sum;
                    r_res.mean       <= r_mean;
                    r_res.maximum    <= r_job.max;
                    r_res.minimum    <= r_job.min;
                    r_res.std_dev    <= r_std;
                    r_res.overflowed <= r_job.drop;
                    r_k              <= '0;
                end
            end
            S_HOUT: begin
                if (n_out_free) begin
                    r_res            <= '0;
                    r_res.kind       <= sbh_pkg::KIND_BIN;
                    r_res.bin_index  <= r_k;
                    r_res.bin_tally  <= bin_rdata;
                    r_res.overflowed <= r_job.drop;
                    r_res.final_res  <= r_k == r_job.n;
                    r_k              <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_res.kind;
    assign o_res.total      = r_res.total;
    assign o_res.mean       = r_res.mean;
    assign o_res.maximum    = r_res.maximum;
    assign o_res.minimum    = r_res.minimum;
    assign o_res.std_dev    = r_res.std_dev;
    assign o_res.bin_index  = r_res.bin_index;
    assign o_res.bin_tally  = r_res.bin_tally;
    assign o_res.overflowed = r_res.overflowed;
    assign o_res.final_res  = r_res.final_res;
endmodule

// ----- rtl/sample_statistics_histogram.sv -----
// Sample statistics with histogram.
//
// Channels: i_in takes samples (unsigned Q16.16) with a last flag; o_res
// gives one statistics beat and then n+1 histogram beats per set, with n
// the bin count clamped to 1..62; i_cfg writes the bin count (always ready,
// reset value 8). Samples are stored one per cycle while i_in.ready is high
// into a 1024-entry store. Beyond that they are dropped and the report flags
// it. The beat with last closes the set; the front then holds i_in.ready
// low until the report is written out. The report is built with the shared
// bit-serial divider (for the mean, the variance and every bin number), one
// store read per cycle for the variance pass, the square root, and then the
// histogram beats. A set whose samples are all equal skips the bin
// divisions. When the receiver stalls, the output register holds its beat
// and the back end waits. Reset empties the set and returns bin_count to 8.
// Depends on sbh_pkg, the channel interfaces, sbh_ram, sbh_front, sbh_back.
module sample_statistics_histogram (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbh_in_if.sink    i_in,
    sbh_cfg_if.sink   i_cfg,
    sbh_out_if.source o_res
);
    logic [sbh_pkg::BIN_W-1:0]    r_bin_count;
    logic                         job_valid;
    logic                         job_ready;
    sbh_pkg::t_job                job;
    logic                         done;
    logic                         ram_we;
    logic [sbh_pkg::ADDR_W-1:0]   ram_waddr;
    logic [sbh_pkg::SAMPLE_W-1:0] ram_wdata;
    logic [sbh_pkg::ADDR_W-1:0]   ram_raddr;
    logic [sbh_pkg::SAMPLE_W-1:0] ram_rdata;

    // Bin count register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= sbh_pkg::BIN_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_bin_count <= i_cfg.bin_count;
        end
    end

    sbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_bin_count (r_bin_count),
        .i_done      (done),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    // Sample store
    sbh_ram #(
        .WIDTH (sbh_pkg::SAMPLE_W),
        .DEPTH (sbh_pkg::MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_done      (done),
        .o_res       (o_res)
    );
endmodule
